// ===== design/miac_pkg.sv =====
// Shared types and character constants for the message insert argument counter.
`default_nettype none

package miac_pkg;

    localparam int CNT_BITS = 10;
    localparam int NUM_BITS = 7;
    localparam int CU_BITS  = 16;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    localparam logic [CU_BITS-1:0] CH_PERCENT = 16'h0025;
    localparam logic [CU_BITS-1:0] CH_BANG    = 16'h0021;
    localparam logic [CU_BITS-1:0] CH_STAR    = 16'h002A;
    localparam logic [CU_BITS-1:0] CH_ZERO    = 16'h0030;
    localparam logic [CU_BITS-1:0] CH_NINE    = 16'h0039;
    localparam logic [3:0]         RADIX      = 4'd10;

    typedef enum logic [2:0] {
        PH_TEXT = 3'd0,
        PH_PCT  = 3'd1,
        PH_DIG1 = 3'd2,
        PH_DIG2 = 3'd3,
        PH_SPEC = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        TK_NONE,
        TK_INDEX,
        TK_NEXT,
        TK_STAR_CLOSE
    } take_t;

    typedef struct packed {
        take_t                take;
        logic [NUM_BITS-1:0]  number;
        logic                 finish;
    } count_cmd_t;

endpackage

`default_nettype wire

// ===== design/miac_ctrl.sv =====
// Scan phase tracking: decodes each code unit into a counter command.
`default_nettype none

module miac_ctrl
    import miac_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step_en,
    input  wire logic [CU_BITS-1:0] cu,
    input  wire logic               eot,
    output count_cmd_t              cmd
);

    phase_t              phase_reg, phase_next;
    logic [NUM_BITS-1:0] number_reg, number_next;
    logic                star_reg, star_next;

    logic                is_digit;
    logic [3:0]          digit;
    logic [10:0]         number_x10;
    phase_t              text_phase;
    take_t               close_take;

    assign is_digit   = (cu >= CH_ZERO) && (cu <= CH_NINE);
    assign digit      = 4'(cu - CH_ZERO);
    assign number_x10 = 11'(number_reg * RADIX) + 11'(digit);
    assign text_phase = (cu == CH_PERCENT) ? PH_PCT : PH_TEXT;
    // star-using inserts close by dropping one index and taking the next
    assign close_take = star_reg ? TK_STAR_CLOSE : TK_INDEX;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        number_next = number_reg;
        star_next   = star_reg;
        if (eot)
        begin
            phase_next  = PH_TEXT;
            number_next = '0;
            star_next   = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_PCT:
                begin
                    if (is_digit)
                    begin
                        number_next = NUM_BITS'(digit);
                        star_next   = 1'b0;
                        phase_next  = PH_DIG1;
                    end
                    else
                    begin
                        phase_next = text_phase;
                    end
                end
                PH_DIG1:
                begin
                    if (is_digit)
                    begin
                        number_next = number_x10[NUM_BITS-1:0];
                        phase_next  = PH_DIG2;
                    end
                    else if (cu == CH_BANG)
                        phase_next = PH_SPEC;
                    else
                        phase_next = text_phase;
                end
                PH_DIG2:
                begin
                    if (cu == CH_BANG)
                        phase_next = PH_SPEC;
                    else
                        phase_next = text_phase;
                end
                PH_SPEC:
                begin
                    if (cu == CH_BANG)
                        phase_next = PH_TEXT;
                    else if (cu == CH_STAR)
                        star_next = 1'b1;
                end
                default:
                begin
                    phase_next = text_phase;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        cmd.take   = TK_NONE;
        cmd.number = number_reg;
        cmd.finish = eot;
        if (eot)
        begin
            if (phase_reg == PH_DIG1 || phase_reg == PH_DIG2 || phase_reg == PH_SPEC)
                cmd.take = close_take;
        end
        else
        begin
            unique case (phase_reg)
                PH_DIG1:
                begin
                    if (!is_digit && cu != CH_BANG)
                        cmd.take = close_take;
                end
                PH_DIG2:
                begin
                    if (cu != CH_BANG)
                        cmd.take = close_take;
                end
                PH_SPEC:
                begin
                    if (cu == CH_BANG)
                        cmd.take = close_take;
                    else if (cu == CH_STAR)
                        cmd.take = star_reg ? TK_NEXT : TK_INDEX;
                end
                default:
                begin
                    cmd.take = TK_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TEXT;
            number_reg <= '0;
            star_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            number_reg <= number_next;
            star_reg   <= star_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/miac_count.sv =====
// Argument counters: highest index and read count with saturation.
`default_nettype none

module miac_count
    import miac_pkg::*;
#(
    parameter int MAX_ARGS = 100
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire count_cmd_t          cmd,
    output logic [CNT_BITS-1:0]      args_read_next,
    output logic [CNT_BITS-1:0]      highest_next,
    output logic                     too_many_next
);

    logic [CNT_BITS-1:0] last_reg, last_next;
    logic [CNT_BITS-1:0] read_reg, read_next;

    logic [CNT_BITS-1:0] number_w;
    logic [CNT_BITS:0]   gap_sum;
    logic [CNT_BITS:0]   inc_sum;
    logic [CNT_BITS-1:0] read_gap;
    logic [CNT_BITS-1:0] read_inc;

    assign number_w = CNT_BITS'(cmd.number);
    assign gap_sum  = {1'b0, read_reg} + {1'b0, 10'(number_w - last_reg)};
    assign inc_sum  = {1'b0, read_reg} + (CNT_BITS+1)'(1);
    assign read_gap = gap_sum[CNT_BITS] ? CNT_MAX : gap_sum[CNT_BITS-1:0];
    assign read_inc = inc_sum[CNT_BITS] ? CNT_MAX : inc_sum[CNT_BITS-1:0];

    always_comb
    begin
        last_next = last_reg;
        read_next = read_reg;
        unique case (cmd.take)
            TK_INDEX:
            begin
                if (number_w > last_reg)
                begin
                    last_next = number_w;
                    read_next = read_gap;
                end
            end
            TK_NEXT:
            begin
                if (last_reg != CNT_MAX)
                begin
                    last_next = last_reg + CNT_BITS'(1);
                    read_next = read_inc;
                end
            end
            TK_STAR_CLOSE:
            begin
                // drop then take next: index unchanged unless the drop wraps below zero
                if (last_reg != '0)
                    read_next = read_inc;
                else
                    last_next = CNT_MAX;
            end
            default:
            begin
                last_next = last_reg;
            end
        endcase
    end

    assign args_read_next = read_next;
    assign highest_next   = last_next;
    assign too_many_next  = read_next > CNT_BITS'(MAX_ARGS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            read_reg <= '0;
        end
        else if (step_en)
        begin
            last_reg <= cmd.finish ? '0 : last_next;
            read_reg <= cmd.finish ? '0 : read_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/message_insert_arg_counter_core.sv =====
// Top level: input register, scan control, counters and result register.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------
//  in      | in_valid / in_stall   | code_unit[15:0], end_of_text
//  out     | out_valid / out_stall | args_read[9:0], highest_index[9:0], too_many, finished
//
// One transfer in and one out per cycle sustained while out_stall is low; an input
// transfer reaches the result through the input register and then the result register.
// Reset clears all scan state; the terminating item also returns it to reset values.
// A stalled output holds the result register; the input register then fills and
// in_stall rises.
`default_nettype none

module message_insert_arg_counter_core
    import miac_pkg::*;
#(
    parameter int MAX_ARGS  = 100,
    parameter int CHAR_BITS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [CU_BITS-1:0]  code_unit,
    input  wire logic                end_of_text,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [CNT_BITS-1:0]      args_read,
    output logic [CNT_BITS-1:0]      highest_index,
    output logic                     too_many,
    output logic                     finished
);

    localparam logic [CU_BITS-1:0] CHAR_MASK = CU_BITS'((32'd1 << CHAR_BITS) - 32'd1);

    logic                in_valid_reg;
    logic [CU_BITS-1:0]  cu_reg;
    logic                eot_reg;

    logic                out_valid_reg;
    logic [CNT_BITS-1:0] args_read_reg;
    logic [CNT_BITS-1:0] highest_reg;
    logic                too_many_reg;
    logic                finished_reg;

    logic                res_ready;
    logic                step_en;
    logic                in_take;

    count_cmd_t          cmd;
    logic [CNT_BITS-1:0] args_read_next;
    logic [CNT_BITS-1:0] highest_next;
    logic                too_many_next;

    assign res_ready = !out_valid_reg || !out_stall;
    assign step_en   = in_valid_reg && res_ready;
    assign in_stall  = in_valid_reg && !res_ready;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (step_en)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cu_reg  <= code_unit & CHAR_MASK;
            eot_reg <= end_of_text;
        end
    end

    miac_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .cu      (cu_reg),
        .eot     (eot_reg),
        .cmd     (cmd)
    );

    miac_count #(
        .MAX_ARGS (MAX_ARGS)
    ) u_count
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .cmd            (cmd),
        .args_read_next (args_read_next),
        .highest_next   (highest_next),
        .too_many_next  (too_many_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            args_read_reg <= args_read_next;
            highest_reg   <= highest_next;
            too_many_reg  <= too_many_next;
            finished_reg  <= cmd.finish;
        end
    end

    assign out_valid     = out_valid_reg;
    assign args_read     = args_read_reg;
    assign highest_index = highest_reg;
    assign too_many      = too_many_reg;
    assign finished      = finished_reg;

endmodule

`default_nettype wire

// ===== bench/tb_message_insert_arg_counter_core.sv =====
// Testbench for message_insert_arg_counter_core: templates checked against a scan predictor.
module tb_message_insert_arg_counter_core
    import miac_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ARGS     = 100;
    localparam int CHAR_BITS    = 16;
    localparam int IDLE_PCT     = 13;
    localparam int HOLD_LEN     = 60;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_UNITS = 120;

    typedef logic [CNT_BITS-1:0] count_t;
    typedef logic [CU_BITS-1:0]  unit_t;
    typedef logic [NUM_BITS-1:0] nr_t;

    typedef struct {
        unit_t unit;
        logic  term;
        logic  drain;
    } char_item_t;

    typedef struct {
        count_t args;
        count_t top;
        logic   over;
        logic   fin;
    } tally_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   in_valid    = 1'b0;
    unit_t  code_unit   = '0;
    logic   end_of_text = 1'b0;
    logic   out_stall   = 1'b0;
    logic   in_stall;
    logic   out_valid;
    count_t args_read;
    count_t highest_index;
    logic   too_many;
    logic   finished;

    // predictor state
    phase_t scan_ph    = PH_TEXT;
    nr_t    insert_nr  = '0;
    logic   star_on    = 1'b0;
    count_t top_index  = '0;
    count_t args_taken = '0;

    char_item_t template_units[$];
    tally_t     tallies_due[$];
    tally_t     next_due;
    logic       drain_next   = 1'b0;
    bit         hold_done    = 1'b0;
    int         hold_left    = 0;
    int         units_sent   = 0;
    int         faults       = 0;
    int         quiet_cycles = 0;

    message_insert_arg_counter_core #(
        .MAX_ARGS  (MAX_ARGS),
        .CHAR_BITS (CHAR_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_unit     (code_unit),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .args_read     (args_read),
        .highest_index (highest_index),
        .too_many      (too_many),
        .finished      (finished)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic bit is_digit(unit_t cu);
        return cu >= CH_ZERO && cu <= CH_NINE;
    endfunction

    function automatic phase_t after_text(unit_t cu);
        return (cu == CH_PERCENT) ? PH_PCT : PH_TEXT;
    endfunction

    function automatic void claim_index(int nr);
        int sum;
        if (nr > int'(top_index))
        begin
            sum        = int'(args_taken) + nr - int'(top_index);
            args_taken = (sum > int'(CNT_MAX)) ? CNT_MAX : count_t'(sum);
            top_index  = count_t'(nr);
        end
    endfunction

    function automatic void claim_next();
        claim_index((top_index < CNT_MAX) ? int'(top_index) + 1 : int'(CNT_MAX));
    endfunction

    // a star-using insert gives back one index before taking the next; may wrap to the top
    function automatic void shut_insert();
        if (star_on)
        begin
            top_index = top_index - 1'b1;
            claim_next();
        end
        else
            claim_index(int'(insert_nr));
    endfunction

    function automatic tally_t scan_unit(unit_t raw, logic term);
        unit_t  cu;
        tally_t t;
        cu = raw & unit_t'((1 << CHAR_BITS) - 1);
        if (term)
        begin
            if (scan_ph == PH_DIG1 || scan_ph == PH_DIG2 || scan_ph == PH_SPEC)
                shut_insert();
        end
        else
        begin
            case (scan_ph)
                PH_PCT:
                    if (is_digit(cu))
                    begin
                        insert_nr = nr_t'(int'(cu) - int'(CH_ZERO));
                        star_on   = 1'b0;
                        scan_ph   = PH_DIG1;
                    end
                    else
                        scan_ph = after_text(cu);
                PH_DIG1:
                    if (is_digit(cu))
                    begin
                        insert_nr = nr_t'(int'(insert_nr) * int'(RADIX)
                                          + int'(cu) - int'(CH_ZERO));
                        scan_ph   = PH_DIG2;
                    end
                    else if (cu == CH_BANG)
                        scan_ph = PH_SPEC;
                    else
                    begin
                        shut_insert();
                        scan_ph = after_text(cu);
                    end
                PH_DIG2:
                    if (cu == CH_BANG)
                        scan_ph = PH_SPEC;
                    else
                    begin
                        shut_insert();
                        scan_ph = after_text(cu);
                    end
                PH_SPEC:
                    if (cu == CH_BANG)
                    begin
                        shut_insert();
                        scan_ph = PH_TEXT;
                    end
                    else if (cu == CH_STAR)
                    begin
                        if (star_on)
                            claim_next();
                        else
                            claim_index(int'(insert_nr));
                        star_on = 1'b1;
                    end
                default:
                    scan_ph = after_text(cu);
            endcase
        end
        t.args = args_taken;
        t.top  = top_index;
        t.over = int'(args_taken) > MAX_ARGS;
        t.fin  = term;
        if (term)
        begin
            scan_ph    = PH_TEXT;
            insert_nr  = '0;
            star_on    = 1'b0;
            top_index  = '0;
            args_taken = '0;
        end
        return t;
    endfunction

    function automatic bit steady_window();
        return units_sent >= 600 && units_sent < 900;
    endfunction

    task automatic push_unit(unit_t u, logic term = 1'b0);
        char_item_t it;
        it.unit    = u;
        it.term    = term;
        it.drain   = drain_next;
        drain_next = 1'b0;
        template_units.push_back(it);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_unit(unit_t'(s[i]));
    endtask

    function automatic unit_t any_text();
        if ($urandom_range(99) < 70)
            return unit_t'($urandom_range(32, 126));
        return unit_t'($urandom_range(65535));
    endfunction

    function automatic unit_t any_digit();
        return CH_ZERO + unit_t'($urandom_range(9));
    endfunction

    task automatic push_insert();
        push_unit(CH_PERCENT);
        push_unit(any_digit());
        if ($urandom_range(1))
        begin
            push_unit(any_digit());
            // a third digit is plain text
            if ($urandom_range(99) < 10)
                push_unit(any_digit());
        end
        if ($urandom_range(1))
        begin
            push_unit(CH_BANG);
            repeat ($urandom_range(4))
            begin
                if ($urandom_range(3) == 0)
                    push_unit(any_text());
                push_unit(CH_STAR);
            end
            if ($urandom_range(99) < 85)
                push_unit(CH_BANG);
        end
    endtask

    task automatic push_template();
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(9))
                0, 1:
                    repeat ($urandom_range(1, 4))
                        push_unit(any_text());
                2:
                    case ($urandom_range(2))
                        0:
                        begin
                            push_unit(CH_PERCENT);
                            push_unit(any_text());
                        end
                        1:
                        begin
                            push_unit(CH_PERCENT);
                            push_unit(CH_PERCENT);
                        end
                        default:
                        begin
                            push_unit(CH_STAR);
                            push_unit(CH_BANG);
                        end
                    endcase
                default:
                    push_insert();
            endcase
        end
        push_unit(unit_t'($urandom_range(65535)), 1'b1);
    endtask

    initial
    begin
        int target;
        // zero unit as text, all-ones unit, percent pairs, third digit, end inside digits
        push_unit('0);
        push_unit('1);
        push_text("%%3x%123%4");
        push_unit('1, 1'b1);
        // star close at index zero wraps the index
        push_text("%0!*!");
        push_unit('0, 1'b1);
        // past the argument array, end inside an open spec
        push_text("%99!***");
        push_unit(CH_PERCENT, 1'b1);

        drain_next = 1'b1;
        target = template_units.size() + RANDOM_UNITS;
        while (template_units.size() < target)
            push_template();

        // drive both counters into saturation
        drain_next = 1'b1;
        repeat (3)
            push_text("%1!*!");
        push_text("%99!");
        repeat (1000)
            push_unit(($urandom_range(31) == 0) ? unit_t'($urandom_range(97, 122)) : CH_STAR);
        push_text("!%7");
        push_unit(unit_t'($urandom_range(65535)), 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (template_units.size() != 0 || in_valid)
            @(posedge clk);
        while (tallies_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("tb_message_insert_arg_counter_core OK");
        else
            $display("tb_message_insert_arg_counter_core NOT OK");
        $finish;
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            code_unit   <= '0;
            end_of_text <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                tallies_due.push_back(scan_unit(code_unit, end_of_text));
                units_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (template_units.size() == 0
                    || (template_units[0].drain && tallies_due.size() != 0)
                    || (!steady_window() && $urandom_range(99) < IDLE_PCT))
                    in_valid <= 1'b0;
                else
                begin
                    in_valid    <= 1'b1;
                    code_unit   <= template_units[0].unit;
                    end_of_text <= template_units[0].term;
                    void'(template_units.pop_front());
                end
            end
        end
    end

    task automatic check_field(string name, count_t got, count_t want);
        if (got !== want)
        begin
            faults++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (tallies_due.size() == 0)
                begin
                    faults++;
                    $display("%0t: unexpected transfer: args_read %0d highest_index %0d %0b %0b",
                             $time, args_read, highest_index, too_many, finished);
                end
                else
                begin
                    next_due = tallies_due.pop_front();
                    check_field("args_read", args_read, next_due.args);
                    check_field("highest_index", highest_index, next_due.top);
                    check_field("too_many", too_many, next_due.over);
                    check_field("finished", finished, next_due.fin);
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && units_sent >= 300)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady_window() && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("tb_message_insert_arg_counter_core NOT OK");
                $finish;
            end
        end
    end

endmodule
